/* hdl/gpm_pkg.sv */
// Shared types and constants for the geofence and proximity monitor.
// Depends on nothing; the top level and gpm_dist refer to it by scoped names.

package gpm_pkg;

   localparam int OBJ_W     = 6;    // object index width on the ports
   localparam int COORD_W   = 16;   // signed Q8.8 coordinate
   localparam int DIST_W    = 15;   // unsigned separation and airspace bound
   localparam int LIMIT_W   = 2 * DIST_W;
   localparam int SQ_W      = 32;   // one squared axis difference
   localparam int SUM_W     = SQ_W + 2;
   localparam int CSR_IDX_W = 4;
   localparam int KIND_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEP      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AIRSPACE_MAX = 4'd1;

   localparam logic [DIST_W-1:0] MIN_SEP_RESET      = 15'd205;
   localparam logic [DIST_W-1:0] AIRSPACE_MAX_RESET = 15'd5120;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_CHECK  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OUT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic    active;
      pos_type pos;
   } entry_type;

endpackage

/* hdl/geofence_and_proximity_monitor.sv */
// Top level of the geofence and proximity monitor: sequencer, object table
// and result register. Depends on gpm_pkg, gpm_ram and gpm_dist.

// Usage
// The req channel carries one item: an update (func = 0) writes the active
// flag and position of one object, a check (func = 1) runs the safety scan.
// The rsp channel carries one result per check and nothing for an update.
// The csr channel writes the minimum separation (index 0) and airspace_max
// (index 1); it is always ready, and other indexes are ignored.
// A check first reads every entry, one per cycle, then walks the rows: each
// row reads its anchor in ST_ROW and takes it in ST_ROW_WAIT, and an active
// row i then reads its partners j > i, one per cycle, and drains the distance
// unit in ST_PAIR_DRAIN. A finding ends the scan at once. The single read
// port of the object table sets this pace: one entry or one pair per cycle.
// After reset the block clears the active flags in the table, with req_stall
// held high; configuration writes are taken.
// Results sit in an output register, so an update or the next check is taken
// while a result waits; a finished check holds in its last state while
// rsp_stall keeps the output register full.

module geofence_and_proximity_monitor #(
   parameter int MAX_OBJECTS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [gpm_pkg::OBJ_W-1:0]              req_object_index,
   input  logic                                   req_active,
   input  logic signed [gpm_pkg::COORD_W-1:0]     req_pos_x,
   input  logic signed [gpm_pkg::COORD_W-1:0]     req_pos_y,
   input  logic signed [gpm_pkg::COORD_W-1:0]     req_pos_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [gpm_pkg::KIND_W-1:0]             rsp_kind,
   output logic [gpm_pkg::OBJ_W-1:0]              rsp_first_object,
   output logic [gpm_pkg::OBJ_W-1:0]              rsp_second_object,
   output logic                                   rsp_alert_latched,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gpm_pkg::DIST_W-1:0]             csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_OBJECTS);
   localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
   localparam int WIDE_W = (CNT_W > gpm_pkg::OBJ_W) ? CNT_W : gpm_pkg::OBJ_W;
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_OBJECTS - 1);
   localparam logic [IDX_W-1:0] PENULT_IDX = IDX_W'(MAX_OBJECTS - 2);
   localparam int ENTRY_W = $bits(gpm_pkg::entry_type);

   typedef enum logic [8:0] {
      ST_CLEAR      = 9'b000000001,
      ST_IDLE       = 9'b000000010,
      ST_BOUNDS     = 9'b000000100,
      ST_BND_DRAIN  = 9'b000001000,
      ST_ROW        = 9'b000010000,
      ST_ROW_WAIT   = 9'b000100000,
      ST_PAIRS      = 9'b001000000,
      ST_PAIR_DRAIN = 9'b010000000,
      ST_RESULT     = 9'b100000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [IDX_W-1:0]                 k_ff, k_in;
   logic [IDX_W-1:0]                 i_ff, i_in;
   logic                             drain_ff, drain_in;
   gpm_pkg::pos_type                 anchor_ff, anchor_in;
   logic [gpm_pkg::KIND_W-1:0]       res_kind_ff, res_kind_in;
   logic [IDX_W-1:0]                 res_first_ff, res_first_in;
   logic [IDX_W-1:0]                 res_second_ff, res_second_in;

   logic                             p1_valid_ff, p1_valid_in;
   logic [IDX_W-1:0]                 p1_idx_ff;

   logic [gpm_pkg::DIST_W-1:0]       min_sep_ff, min_sep_in;
   logic [gpm_pkg::DIST_W-1:0]       airspace_max_ff, airspace_max_in;
   logic [gpm_pkg::LIMIT_W-1:0]      limit_ff, limit_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff;
   logic [gpm_pkg::KIND_W-1:0]       rsp_kind_ff;
   logic [gpm_pkg::OBJ_W-1:0]        rsp_first_ff, rsp_second_ff;
   logic                             alert_ff, alert_in;

   logic                             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]                 ram_wr_addr, ram_rd_addr;
   gpm_pkg::entry_type               ram_wr_data, ram_rd_data;

   logic                             req_accept;
   logic                             csr_accept;
   logic                             in_range;
   logic [WIDE_W-1:0]                idx_wide;
   logic                             bound_hit;
   logic                             dist_in_valid;
   logic                             dist_hit;
   logic [IDX_W-1:0]                 dist_hit_idx;
   logic                             rsp_load;

   function automatic logic outside(input logic signed [gpm_pkg::COORD_W-1:0] c,
                                    input logic [gpm_pkg::DIST_W-1:0] lim);
      return c[gpm_pkg::COORD_W-1] | (c[gpm_pkg::DIST_W-1:0] > lim);
   endfunction

   // Table of objects: one word holds the active flag and the position.
   gpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_OBJECTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gpm_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dist_in_valid),
      .in_idx   (p1_idx_ff),
      .anchor   (anchor_ff),
      .entry    (ram_rd_data.pos),
      .limit    (limit_ff),
      .hit      (dist_hit),
      .hit_idx  (dist_hit_idx)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // Updates beyond the table are dropped.
   assign idx_wide = WIDE_W'(req_object_index);
   assign in_range = (idx_wide < WIDE_W'(MAX_OBJECTS));

   // The entry read in the previous cycle is tagged by p1; the bounds test
   // looks at it during the bounds scan, the distance unit during the pairs.
   assign bound_hit = p1_valid_ff && ram_rd_data.active
                    && ((state_ff == ST_BOUNDS) || (state_ff == ST_BND_DRAIN))
                    && (outside(ram_rd_data.pos.x, airspace_max_ff)
                        || outside(ram_rd_data.pos.y, airspace_max_ff)
                        || outside(ram_rd_data.pos.z, airspace_max_ff));
   assign dist_in_valid = p1_valid_ff && ram_rd_data.active
                        && ((state_ff == ST_PAIRS) || (state_ff == ST_PAIR_DRAIN));

   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer. The table is written only in the clearing pass and in idle,
   // and read only during a check, so reads and writes never meet on one
   // entry.
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      drain_in      = drain_ff;
      anchor_in     = anchor_ff;
      res_kind_in   = res_kind_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = k_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = k_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == gpm_pkg::FUNC_CHECK) begin
                  k_in     = '0;
                  state_in = ST_BOUNDS;
               end else begin
                  ram_wr_en          = in_range;
                  ram_wr_addr        = idx_wide[IDX_W-1:0];
                  ram_wr_data.active = req_active;
                  ram_wr_data.pos.x  = req_pos_x;
                  ram_wr_data.pos.y  = req_pos_y;
                  ram_wr_data.pos.z  = req_pos_z;
               end
            end
         end
         ST_BOUNDS: begin
            ram_rd_en = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == LAST_IDX) begin
               state_in = ST_BND_DRAIN;
            end
            if (bound_hit) begin
               res_kind_in   = gpm_pkg::KIND_OUT;
               res_first_in  = p1_idx_ff;
               res_second_in = '0;
               state_in      = ST_RESULT;
            end
         end
         ST_BND_DRAIN: begin
            if (bound_hit) begin
               res_kind_in   = gpm_pkg::KIND_OUT;
               res_first_in  = p1_idx_ff;
               res_second_in = '0;
               state_in      = ST_RESULT;
            end else begin
               i_in     = '0;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = i_ff;
            state_in    = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            anchor_in = ram_rd_data.pos;
            if (ram_rd_data.active) begin
               k_in     = i_ff + 1'b1;
               state_in = ST_PAIRS;
            end else if (i_ff == PENULT_IDX) begin
               res_kind_in   = gpm_pkg::KIND_NONE;
               res_first_in  = '0;
               res_second_in = '0;
               state_in      = ST_RESULT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_PAIRS: begin
            ram_rd_en = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == LAST_IDX) begin
               drain_in = 1'b0;
               state_in = ST_PAIR_DRAIN;
            end
            if (dist_hit) begin
               res_kind_in   = gpm_pkg::KIND_CLOSE;
               res_first_in  = i_ff;
               res_second_in = dist_hit_idx;
               state_in      = ST_RESULT;
            end
         end
         ST_PAIR_DRAIN: begin
            drain_in = 1'b1;
            if (dist_hit) begin
               res_kind_in   = gpm_pkg::KIND_CLOSE;
               res_first_in  = i_ff;
               res_second_in = dist_hit_idx;
               state_in      = ST_RESULT;
            end else if (drain_ff) begin
               if (i_ff == PENULT_IDX) begin
                  res_kind_in   = gpm_pkg::KIND_NONE;
                  res_first_in  = '0;
                  res_second_in = '0;
                  state_in      = ST_RESULT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ROW;
               end
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign p1_valid_in = ram_rd_en && ((state_ff == ST_BOUNDS) || (state_ff == ST_PAIRS));

   always_comb begin
      min_sep_in      = min_sep_ff;
      airspace_max_in = airspace_max_ff;
      if (csr_accept) begin
         if (csr_index == gpm_pkg::CSR_MIN_SEP) begin
            min_sep_in = csr_wdata;
         end else if (csr_index == gpm_pkg::CSR_AIRSPACE_MAX) begin
            airspace_max_in = csr_wdata;
         end
      end
   end

   // Squared separation, registered; the user must change configuration only while idle, the block does not enforce it.
   assign limit_in = gpm_pkg::LIMIT_W'(min_sep_ff) * gpm_pkg::LIMIT_W'(min_sep_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      alert_in     = alert_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         alert_in     = alert_ff | (res_kind_ff != gpm_pkg::KIND_NONE);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         k_ff            <= '0;
         drain_ff        <= 1'b0;
         p1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         alert_ff        <= 1'b0;
         min_sep_ff      <= gpm_pkg::MIN_SEP_RESET;
         airspace_max_ff <= gpm_pkg::AIRSPACE_MAX_RESET;
      end else begin
         state_ff        <= state_in;
         k_ff            <= k_in;
         drain_ff        <= drain_in;
         p1_valid_ff     <= p1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         alert_ff        <= alert_in;
         min_sep_ff      <= min_sep_in;
         airspace_max_ff <= airspace_max_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      anchor_ff     <= anchor_in;
      res_kind_ff   <= res_kind_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      p1_idx_ff     <= ram_rd_addr;
      limit_ff      <= limit_in;
      if (rsp_load) begin
         rsp_found_ff  <= (res_kind_ff != gpm_pkg::KIND_NONE);
         rsp_kind_ff   <= res_kind_ff;
         rsp_first_ff  <= gpm_pkg::OBJ_W'(res_first_ff);
         rsp_second_ff <= gpm_pkg::OBJ_W'(res_second_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_first_object  = rsp_first_ff;
   assign rsp_second_object = rsp_second_ff;
   assign rsp_alert_latched = alert_ff;

   // The table is never written while a check is reading it.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == ST_IDLE) || (state_ff == ST_CLEAR)))
      else $error("table written during a check");

   // The partner index of a pair always lies above the anchor row.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIRS) |-> (k_ff > i_ff))
      else $error("pair walk below its anchor row");

   // The alert flag is sticky until reset.
   assert property (@(posedge clock) disable iff (reset)
      alert_ff |=> alert_ff)
      else $error("alert flag cleared without reset");

   // A shown result reports a finding exactly when it names a kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff == (rsp_kind_ff != gpm_pkg::KIND_NONE)))
      else $error("found and kind disagree");

   // A loaded finding always raises the registered alert flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (res_kind_ff != gpm_pkg::KIND_NONE)) |=> alert_ff)
      else $error("finding did not raise the alert");

endmodule

/* hdl/gpm_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.

module gpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gpm_dist.sv */
// Two-stage squared-distance unit: axis differences and squares, then the sum
// and the compare against the squared separation. Depends on gpm_pkg.

module gpm_dist #(
   parameter int IDX_W = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [IDX_W-1:0]               in_idx,
   input  gpm_pkg::pos_type               anchor,
   input  gpm_pkg::pos_type               entry,
   input  logic [gpm_pkg::LIMIT_W-1:0]    limit,
   output logic                           hit,
   output logic [IDX_W-1:0]               hit_idx
);

   logic signed [gpm_pkg::COORD_W:0]       dx, dy, dz;
   logic signed [2*gpm_pkg::COORD_W+1:0]   px, py, pz;
   logic [gpm_pkg::SQ_W-1:0]               sq_x_in, sq_y_in, sq_z_in;
   logic [gpm_pkg::SQ_W-1:0]               sq_x_ff, sq_y_ff, sq_z_ff;
   logic                                   valid_ff;
   logic [IDX_W-1:0]                       idx_ff;
   logic [gpm_pkg::SUM_W-1:0]              sum;

   // Differences are exact in 17 bits; each square stays below 2^32.
   always_comb begin
      dx = $signed({anchor.x[gpm_pkg::COORD_W-1], anchor.x})
         - $signed({entry.x[gpm_pkg::COORD_W-1], entry.x});
      dy = $signed({anchor.y[gpm_pkg::COORD_W-1], anchor.y})
         - $signed({entry.y[gpm_pkg::COORD_W-1], entry.y});
      dz = $signed({anchor.z[gpm_pkg::COORD_W-1], anchor.z})
         - $signed({entry.z[gpm_pkg::COORD_W-1], entry.z});
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
      sq_x_in = px[gpm_pkg::SQ_W-1:0];
      sq_y_in = py[gpm_pkg::SQ_W-1:0];
      sq_z_in = pz[gpm_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
      idx_ff  <= in_idx;
   end

   assign sum = gpm_pkg::SUM_W'(sq_x_ff) + gpm_pkg::SUM_W'(sq_y_ff)
              + gpm_pkg::SUM_W'(sq_z_ff);
   assign hit     = valid_ff && (sum < gpm_pkg::SUM_W'(limit));
   assign hit_idx = idx_ff;

endmodule
